// ===== rtl/core/ptpd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptpd_pkg
// Shared types and constants for the proximity touch press decoder.
// ----------------------------------------------------------------------------
package ptpd_pkg;

  localparam int MODE_COUNT  = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // d*d >= 100000 first holds at 317 ms
  localparam logic [31:0] LEVEL_ON_MS  = 32'd317;
  localparam logic [31:0] LEVEL_SAT_MS = 32'd6000;
  localparam logic [8:0]  LEVEL_MAX    = 9'd360;

  // floor(x / 100000) as (x * LVL_RECIP) >> LVL_SHIFT, exact for x < 2^26
  localparam int          LVL_SHIFT   = 43;
  localparam logic [63:0] LVL_RECIP_W = ((64'd1 << LVL_SHIFT) + 64'd99999) / 64'd100000;
  localparam logic [26:0] LVL_RECIP   = LVL_RECIP_W[26:0];

  // floor(level * 8192 / 45) as (level * BR_RECIP) >> (BR_SHIFT - 13)
  localparam int          BR_SHIFT   = 28;
  localparam logic [63:0] BR_RECIP_W = ((64'd1 << BR_SHIFT) + 64'd44) / 64'd45;
  localparam logic [22:0] BR_RECIP   = BR_RECIP_W[22:0];

  // floor(x / 10800) as (x * HUE_RECIP) >> HUE_SHIFT, exact for 32-bit x
  localparam int          HUE_DIV     = 10800;
  localparam int          HUE_SHIFT   = 46;
  localparam logic [63:0] HUE_RECIP_W =
    ((64'd1 << HUE_SHIFT) + 64'(HUE_DIV - 1)) / 64'(HUE_DIV);
  localparam logic [32:0] HUE_RECIP   = HUE_RECIP_W[32:0];

  localparam logic [15:0] BRIGHT_RESET = 16'd45875;
  localparam logic [16:0] BRIGHT_MIN   = 17'd262;
  localparam logic [16:0] BRIGHT_SAT   = 17'd65535;

  typedef enum logic [1:0] {
    CLS_EQUAL,
    CLS_PRESS,
    CLS_RELEASE
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [31:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        bright_init;
    logic [31:0] bright_len;
    logic        hue_set;
    logic [31:0] hue_len;
    logic        lvl_live;
    logic [31:0] press_length;
    logic        holding;
    logic        advanced;
  } event_t;

endpackage

// ===== rtl/core/ptpd_front.sv =====
// ----------------------------------------------------------------------------
// ptpd_front
// Accepts samples, classifies them against the threshold and queues them.
// ----------------------------------------------------------------------------
module ptpd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        press_threshold,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        proximity,
  input  logic [31:0]       now_ms,
  input  logic              pop,
  output logic              head_valid,
  output ptpd_pkg::sample_t head
);
  import ptpd_pkg::*;

  sample_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  sample_t           incoming;

  always_comb begin
    incoming.now_ms = now_ms;
    if (proximity > press_threshold) begin
      incoming.cls = CLS_PRESS;
    end else if (proximity < press_threshold) begin
      incoming.cls = CLS_RELEASE;
    end else begin
      incoming.cls = CLS_EQUAL;
    end
  end

  assign in_stall   = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/core/ptpd_core.sv =====
// ----------------------------------------------------------------------------
// ptpd_core
// Press state machine: start, double click, hold and release per word.
// ----------------------------------------------------------------------------
module ptpd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       double_gap_ms,
  input  logic [15:0]       tap_max_ms,
  input  logic              head_valid,
  input  ptpd_pkg::sample_t head,
  input  logic              ready,
  output logic              pop,
  output ptpd_pkg::event_t  evt
);
  import ptpd_pkg::*;

  logic [31:0] press_start,       press_start_next;
  logic [31:0] press_length,      press_length_next;
  logic [31:0] last_press_length, last_press_length_next;
  logic [31:0] last_release_time, last_release_time_next;
  logic [1:0]  mode,              mode_next;
  logic        lvl_live,          lvl_live_next;
  logic        lvl_nz,            lvl_nz_next;
  logic        bright_init,       bright_init_next;
  logic [31:0] bright_len,        bright_len_next;
  logic        hue_set,           hue_set_next;
  logic [31:0] hue_len,           hue_len_next;
  logic        advanced;
  logic        idle;
  logic [31:0] held;
  logic [31:0] since_release;

  assign pop           = head_valid && ready;
  assign idle          = (press_start == '0);
  assign held          = head.now_ms - press_start;
  assign since_release = head.now_ms - last_release_time;

  always_comb begin
    press_start_next       = press_start;
    press_length_next      = press_length;
    last_press_length_next = last_press_length;
    last_release_time_next = last_release_time;
    mode_next              = mode;
    lvl_live_next          = lvl_live;
    lvl_nz_next            = lvl_nz;
    bright_init_next       = bright_init;
    bright_len_next        = bright_len;
    hue_set_next           = hue_set;
    hue_len_next           = hue_len;
    advanced               = 1'b0;
    if (idle) begin
      if (head.cls == CLS_PRESS) begin
        press_start_next = head.now_ms;
        if ((since_release < {16'd0, double_gap_ms}) &&
            (last_press_length < {16'd0, tap_max_ms})) begin
          mode_next = (mode == 2'(MODE_COUNT - 1)) ? 2'd0 : mode + 2'd1;
          lvl_live_next          = 1'b0;
          lvl_nz_next            = 1'b0;
          last_release_time_next = '0;
          last_press_length_next = '0;
          advanced               = 1'b1;
        end
      end
    end else if (head.cls == CLS_RELEASE) begin
      if (lvl_nz) begin
        if (mode == 2'd0) begin
          bright_init_next = 1'b0;
          bright_len_next  = press_length;
        end else if (mode == 2'd1) begin
          hue_set_next = 1'b1;
          hue_len_next = press_length;
        end
      end
      last_release_time_next = head.now_ms;
      last_press_length_next = held;
      press_start_next       = '0;
      lvl_live_next          = 1'b0;
      lvl_nz_next            = 1'b0;
    end else begin
      press_length_next = held;
      lvl_live_next     = 1'b1;
      lvl_nz_next       = (held >= LEVEL_ON_MS);
    end
  end

  always_comb begin
    evt.mode         = mode_next;
    evt.bright_init  = bright_init_next;
    evt.bright_len   = bright_len_next;
    evt.hue_set      = hue_set_next;
    evt.hue_len      = hue_len_next;
    evt.lvl_live     = lvl_live_next;
    evt.press_length = press_length_next;
    evt.holding      = (press_start_next != '0);
    evt.advanced     = advanced;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_start       <= '0;
      press_length      <= '0;
      last_press_length <= '0;
      last_release_time <= '0;
      mode              <= '0;
      lvl_live          <= 1'b0;
      lvl_nz            <= 1'b0;
      bright_init       <= 1'b1;
      bright_len        <= '0;
      hue_set           <= 1'b0;
      hue_len           <= '0;
    end else if (pop) begin
      press_start       <= press_start_next;
      press_length      <= press_length_next;
      last_press_length <= last_press_length_next;
      last_release_time <= last_release_time_next;
      mode              <= mode_next;
      lvl_live          <= lvl_live_next;
      lvl_nz            <= lvl_nz_next;
      bright_init       <= bright_init_next;
      bright_len        <= bright_len_next;
      hue_set           <= hue_set_next;
      hue_len           <= hue_len_next;
    end
  end

endmodule

// ===== rtl/core/ptpd_post.sv =====
// ----------------------------------------------------------------------------
// ptpd_post
// Value pipeline: level, brightness and hue arithmetic, output register.
// ----------------------------------------------------------------------------
module ptpd_post (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  ptpd_pkg::event_t evt,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       light_mode,
  output logic [15:0]      brightness_frac,
  output logic [13:0]      hue_thirtieths,
  output logic [8:0]       live_level,
  output logic [31:0]      held_ms,
  output logic             holding,
  output logic             mode_advanced
);
  import ptpd_pkg::*;

  logic adv1, adv2, adv3, adv4;
  logic v1, v2, v3;

  // stage 1: squares and hue quotient
  event_t      e1;
  logic [25:0] sq_live, sq_br;
  logic        sat_live, sat_br;
  logic [18:0] hue_q;
  logic [64:0] hue_prod;

  // stage 2: levels and hue remainder
  logic [1:0]  mode2;
  logic        bright_init2, hue_set2, holding2, adv_flag2;
  logic [31:0] press_length2;
  logic [8:0]  live_level2, br_level2;
  logic [13:0] hue_r2;
  logic [52:0] lprod_live, lprod_br;
  logic [8:0]  level_live_c, level_br_c;
  logic [31:0] hue_rem;

  // stage 3: brightness product
  logic [1:0]  mode3;
  logic        bright_init3, hue_set3, holding3, adv_flag3;
  logic [31:0] press_length3;
  logic [8:0]  live_level3;
  logic [13:0] hue_r3;
  logic [31:0] bprod3;
  logic [16:0] braw;
  logic [15:0] bright_c;

  assign adv4  = !out_valid || !out_stall;
  assign adv3  = !v3 || adv4;
  assign adv2  = !v2 || adv3;
  assign adv1  = !v1 || adv2;
  assign ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) out_valid <= v3;
    end
  end

  assign hue_prod = {33'd0, evt.hue_len} * {32'd0, HUE_RECIP};

  always_ff @(posedge clk) begin
    if (adv1) begin
      e1       <= evt;
      sq_live  <= 26'(evt.press_length[12:0]) * 26'(evt.press_length[12:0]);
      sat_live <= (evt.press_length >= LEVEL_SAT_MS);
      sq_br    <= 26'(evt.bright_len[12:0]) * 26'(evt.bright_len[12:0]);
      sat_br   <= (evt.bright_len >= LEVEL_SAT_MS);
      hue_q    <= hue_prod[64:46];
    end
  end

  always_comb begin
    lprod_live = {27'd0, sq_live} * {26'd0, LVL_RECIP};
    lprod_br   = {27'd0, sq_br} * {26'd0, LVL_RECIP};
    if (sat_live || (lprod_live[52:43] > {1'b0, LEVEL_MAX})) begin
      level_live_c = LEVEL_MAX;
    end else begin
      level_live_c = lprod_live[51:43];
    end
    if (sat_br || (lprod_br[52:43] > {1'b0, LEVEL_MAX})) begin
      level_br_c = LEVEL_MAX;
    end else begin
      level_br_c = lprod_br[51:43];
    end
    hue_rem = e1.hue_len - ({13'd0, hue_q} * 32'(HUE_DIV));
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      mode2         <= e1.mode;
      bright_init2  <= e1.bright_init;
      hue_set2      <= e1.hue_set;
      holding2      <= e1.holding;
      adv_flag2     <= e1.advanced;
      press_length2 <= e1.press_length;
      live_level2   <= e1.lvl_live ? level_live_c : 9'd0;
      br_level2     <= level_br_c;
      hue_r2        <= hue_rem[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      mode3         <= mode2;
      bright_init3  <= bright_init2;
      hue_set3      <= hue_set2;
      holding3      <= holding2;
      adv_flag3     <= adv_flag2;
      press_length3 <= press_length2;
      live_level3   <= live_level2;
      hue_r3        <= hue_r2;
      bprod3        <= {23'd0, br_level2} * {9'd0, BR_RECIP};
    end
  end

  always_comb begin
    braw = bprod3[31:15];
    if (bright_init3) begin
      bright_c = BRIGHT_RESET;
    end else if (braw < BRIGHT_MIN) begin
      bright_c = BRIGHT_MIN[15:0];
    end else if (braw > BRIGHT_SAT) begin
      bright_c = BRIGHT_SAT[15:0];
    end else begin
      bright_c = braw[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      light_mode      <= mode3;
      brightness_frac <= bright_c;
      hue_thirtieths  <= hue_set3 ? hue_r3 : 14'd0;
      live_level      <= live_level3;
      held_ms         <= press_length3;
      holding         <= holding3;
      mode_advanced   <= adv_flag3;
    end
  end

endmodule

// ===== rtl/core/proximity_touch_press_decoder.sv =====
// ----------------------------------------------------------------------------
// proximity_touch_press_decoder
// Decodes proximity samples into presses, double clicks, levels and settings.
// ----------------------------------------------------------------------------
// Path from sample acceptance to result valid: queue, press state machine,
// three arithmetic stages and the output register. Throughput: one sample
// per cycle unless stalled; the press state machine takes one queued word
// per cycle while the value pipeline is ready. Reset: press state cleared,
// brightness 0.7, registers to threshold 15, double gap 300 ms, tap limit 100 ms.
// ----------------------------------------------------------------------------
module proximity_touch_press_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  proximity,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  light_mode,
  output logic [15:0] brightness_frac,
  output logic [13:0] hue_thirtieths,
  output logic [8:0]  live_level,
  output logic [31:0] held_ms,
  output logic        holding,
  output logic        mode_advanced
);
  import ptpd_pkg::*;

  localparam logic [1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_DOUBLE_GAP = 2'd1;
  localparam logic [1:0] REG_TAP_MAX    = 2'd2;

  logic [7:0]  press_threshold;
  logic [15:0] double_gap_ms;
  logic [15:0] tap_max_ms;
  logic        cfg_write;

  logic    head_valid;
  sample_t head;
  logic    pop;
  logic    core_ready;
  event_t  evt;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_threshold <= 8'd15;
      double_gap_ms   <= 16'd300;
      tap_max_ms      <= 16'd100;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_THRESHOLD:  press_threshold <= pwdata[7:0];
        REG_DOUBLE_GAP: double_gap_ms   <= pwdata[15:0];
        REG_TAP_MAX:    tap_max_ms      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_THRESHOLD:  prdata = {24'd0, press_threshold};
      REG_DOUBLE_GAP: prdata = {16'd0, double_gap_ms};
      REG_TAP_MAX:    prdata = {16'd0, tap_max_ms};
      default:        prdata = '0;
    endcase
  end

  ptpd_front u_front (
    .clk             (clk),
    .rst             (rst),
    .press_threshold (press_threshold),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .proximity       (proximity),
    .now_ms          (now_ms),
    .pop             (pop),
    .head_valid      (head_valid),
    .head            (head)
  );

  ptpd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .double_gap_ms (double_gap_ms),
    .tap_max_ms    (tap_max_ms),
    .head_valid    (head_valid),
    .head          (head),
    .ready         (core_ready),
    .pop           (pop),
    .evt           (evt)
  );

  ptpd_post u_post (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (head_valid),
    .evt             (evt),
    .ready           (core_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .light_mode      (light_mode),
    .brightness_frac (brightness_frac),
    .hue_thirtieths  (hue_thirtieths),
    .live_level      (live_level),
    .held_ms         (held_ms),
    .holding         (holding),
    .mode_advanced   (mode_advanced)
  );

endmodule

// ===== bench/ptpd_press_checker.sv =====
// ----------------------------------------------------------------------------
// ptpd_press_checker
// Register map and light modes for the bench, and a checker that watches the
// sample, result and register ports of the press decoder, predicts each
// result word from the accepted samples and compares it field by field.
// ----------------------------------------------------------------------------
package ptpd_bench_pkg;

  typedef enum logic [3:0] {
    REG_THRESHOLD  = 4'h0,
    REG_DOUBLE_GAP = 4'h4,
    REG_TAP_MAX    = 4'h8
  } reg_addr_t;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_HUE,
    MODE_SWEEP,
    MODE_CYCLE
  } light_mode_t;

endpackage

module ptpd_press_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  proximity,
  input  logic [31:0] now_ms,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  light_mode,
  input  logic [15:0] brightness_frac,
  input  logic [13:0] hue_thirtieths,
  input  logic [8:0]  live_level,
  input  logic [31:0] held_ms,
  input  logic        holding,
  input  logic        mode_advanced,
  output int          mismatches,
  output int          words_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ptpd_pkg::*;
  import ptpd_bench_pkg::*;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] bright;
    logic [13:0] hue;
    logic [8:0]  level;
    logic [31:0] held;
    logic        holding;
    logic        advanced;
  } press_word_t;

  logic [7:0]  thr;
  logic [15:0] gap_ms;
  logic [15:0] tap_ms;

  logic [31:0] press_t0;
  logic [8:0]  lvl;
  logic [31:0] press_len;
  logic [31:0] prev_len;
  logic [31:0] prev_release;
  light_mode_t mode;
  logic [15:0] bright;
  logic [13:0] hue;

  press_word_t words_due[$];
  int          fails = 0;

  assign mismatches = fails;

  function automatic logic [8:0] level_for(logic [31:0] d);
    logic [63:0] sq;
    if (d >= LEVEL_SAT_MS) return LEVEL_MAX;
    sq = (64'(d) * 64'(d)) / 64'd100000;
    return (sq > 64'd360) ? LEVEL_MAX : sq[8:0];
  endfunction

  task automatic decode_sample(logic [7:0] prox, logic [31:0] t);
    press_word_t w;
    logic [31:0] b;
    logic        adv;
    adv = 1'b0;
    if (press_t0 == '0 && prox > thr) begin
      press_t0 = t;
      if (t - prev_release < 32'(gap_ms) && prev_len < 32'(tap_ms)) begin
        mode         = light_mode_t'((int'(mode) + 1) % MODE_COUNT);
        lvl          = '0;
        prev_release = '0;
        prev_len     = '0;
        adv          = 1'b1;
      end
    end else if (press_t0 != '0) begin
      if (prox < thr) begin
        if (lvl != '0) begin
          if (mode == MODE_PLAIN) begin
            b = (32'(lvl) * 32'd65536) / 32'd360;
            if (b < 32'd262) b = 32'd262;
            if (b > 32'd65535) b = 32'd65535;
            bright = b[15:0];
          end else if (mode == MODE_HUE) begin
            hue = 14'(press_len % 32'd10800);
          end
        end
        prev_release = t;
        prev_len     = t - press_t0;
        press_t0     = '0;
        lvl          = '0;
      end else begin
        lvl       = level_for(t - press_t0);
        press_len = t - press_t0;
      end
    end
    w = '{mode: mode, bright: bright, hue: hue, level: lvl, held: press_len,
          holding: (press_t0 != '0), advanced: adv};
    words_due.push_back(w);
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_word();
    press_word_t e;
    if (words_due.size() == 0) begin
      fails++;
      $display("%0t: result word with none expected, mode %0d level %0d held %0d",
               $time, light_mode, live_level, held_ms);
      return;
    end
    e = words_due.pop_front();
    compare_field("light_mode", 32'(e.mode), 32'(light_mode));
    compare_field("brightness_frac", 32'(e.bright), 32'(brightness_frac));
    compare_field("hue_thirtieths", 32'(e.hue), 32'(hue_thirtieths));
    compare_field("live_level", 32'(e.level), 32'(live_level));
    compare_field("held_ms", e.held, held_ms);
    compare_field("holding", 32'(e.holding), 32'(holding));
    compare_field("mode_advanced", 32'(e.advanced), 32'(mode_advanced));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      thr          = 8'd15;
      gap_ms       = 16'd300;
      tap_ms       = 16'd100;
      press_t0     = '0;
      lvl          = '0;
      press_len    = '0;
      prev_len     = '0;
      prev_release = '0;
      mode         = MODE_PLAIN;
      bright       = BRIGHT_RESET;
      hue          = '0;
      words_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          REG_THRESHOLD:  thr    = pwdata[7:0];
          REG_DOUBLE_GAP: gap_ms = pwdata[15:0];
          REG_TAP_MAX:    tap_ms = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_sample(proximity, now_ms);
      if (out_valid && !out_stall) check_word();
    end
    words_pending <= words_due.size();
  end

endmodule

// ===== bench/tb_proximity_touch_press_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_proximity_touch_press_decoder
// Drives proximity samples as press, hold, tap and double-click sequences with
// random timing, noise and broken sequences, under several register settings,
// with random idling on both channels and one long result hold-off. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_proximity_touch_press_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import ptpd_bench_pkg::*;

  localparam int unsigned LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  proximity;
  logic [31:0] now_ms;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  light_mode;
  logic [15:0] brightness_frac;
  logic [13:0] hue_thirtieths;
  logic [8:0]  live_level;
  logic [31:0] held_ms;
  logic        holding;
  logic        mode_advanced;

  int          errors;
  int          pending;
  int unsigned cyc = 0;
  int unsigned n_words = 0;
  int unsigned calm = 0;
  bit          quiet = 1'b0;
  bit          squeeze_req = 1'b0;
  bit          squeeze_ack = 1'b0;
  logic [7:0]  thr_cur = 8'd15;
  logic [31:0] t_ms = 32'd1000;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  proximity_touch_press_decoder i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .proximity(proximity), .now_ms(now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .light_mode(light_mode), .brightness_frac(brightness_frac),
    .hue_thirtieths(hue_thirtieths), .live_level(live_level),
    .held_ms(held_ms), .holding(holding), .mode_advanced(mode_advanced)
  );

  ptpd_press_checker i_chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .proximity(proximity), .now_ms(now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .light_mode(light_mode), .brightness_frac(brightness_frac),
    .hue_thirtieths(hue_thirtieths), .live_level(live_level),
    .held_ms(held_ms), .holding(holding), .mode_advanced(mode_advanced),
    .mismatches(errors), .words_pending(pending)
  );

  always @(posedge clk) cyc <= cyc + 1;

  initial begin
    wait (cyc == LIMIT);
    $display("FAIL proximity_touch_press_decoder");
    $finish;
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (squeeze_req && !squeeze_ack) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
        squeeze_ack = 1'b1;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 25)) @(posedge clk);
    end
  end

  task automatic send_word(logic [7:0] prox, logic [31:0] ts);
    if (calm > 0) begin
      calm--;
    end else if (!quiet) begin
      if ($urandom_range(0, 7) == 0) begin
        calm = $urandom_range(5, 30);
      end else if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    proximity <= prox;
    now_ms    <= ts;
    do @(posedge clk); while (in_stall);
    n_words++;
  endtask

  function automatic logic [7:0] above_thr();
    if (thr_cur == 8'hFF) return 8'hFF;
    return 8'($urandom_range(int'(thr_cur) + 1, 255));
  endfunction

  function automatic logic [7:0] below_thr();
    if (thr_cur == 8'h00) return 8'h00;
    return 8'($urandom_range(0, int'(thr_cur) - 1));
  endfunction

  function automatic logic [7:0] hold_prox();
    return ($urandom_range(0, 2) == 0) ? thr_cur : above_thr();
  endfunction

  task automatic reg_write(reg_addr_t addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic configure(logic [7:0] thr, logic [15:0] gap, logic [15:0] tap);
    wait_drained();
    reg_write(REG_THRESHOLD, 32'(thr));
    reg_write(REG_DOUBLE_GAP, 32'(gap));
    reg_write(REG_TAP_MAX, 32'(tap));
    thr_cur = thr;
  endtask

  // press, a few holds spread over the duration, then usually a release
  task automatic press_seq(int unsigned dur, int unsigned pre);
    int unsigned holds;
    logic [31:0] t0;
    holds = $urandom_range(0, 4);
    repeat ($urandom_range(0, 2)) begin
      t_ms += 32'($urandom_range(1, 50));
      send_word(below_thr(), t_ms);
    end
    t_ms += 32'(pre);
    t0 = t_ms;
    send_word(above_thr(), t0);
    for (int unsigned k = 1; k <= holds; k++)
      send_word(hold_prox(), t0 + 32'(dur * k / holds));
    t_ms = t0 + 32'(dur) + 32'($urandom_range(0, 2));
    if ($urandom_range(0, 9) != 0) send_word(below_thr(), t_ms);
  endtask

  task automatic random_press();
    int unsigned r;
    int unsigned dur;
    int unsigned pre;
    r   = $urandom_range(0, 9);
    dur = (r < 4) ? $urandom_range(0, 150) :
          (r < 8) ? $urandom_range(150, 3000) : $urandom_range(3000, 9000);
    pre = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 350) : $urandom_range(1, 100000);
    press_seq(dur, pre);
  endtask

  task automatic random_traffic(int unsigned n);
    int unsigned goal;
    goal = n_words + n;
    while (n_words < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)), $urandom());
        if ($urandom_range(0, 1) == 0) t_ms = $urandom();
      end else begin
        random_press();
      end
    end
  endtask

  task automatic directed();
    send_word(8'd15, 32'd10);
    send_word(8'd16, 32'd50);
    send_word(8'd15, 32'd400);
    send_word(8'd200, 32'd7000);
    send_word(8'd0, 32'd7010);
    send_word(8'd255, 32'd0);
    send_word(8'd100, 32'd7050);
    send_word(8'd0, 32'd7100);
    send_word(8'd20, 32'd7200);
    send_word(8'd15, 32'd7300);
    send_word(8'd14, 32'd7400);
    send_word(8'd30, 32'd7450);
    send_word(8'd3, 32'd7460);
    send_word(8'd30, 32'd7500);
    send_word(8'd3, 32'd7510);
    send_word(8'd30, 32'd7520);
    send_word(8'd80, 32'd13519);
    send_word(8'd0, 32'd13530);
    send_word(8'd90, 32'hFFFF_FFFF);
    send_word(8'd15, 32'h0000_021F);
    send_word(8'd1, 32'h0000_0300);
    send_word(8'd200, 32'd100000);
    send_word(8'd50, 32'd100400);
    send_word(8'd0, 32'd100401);
    send_word(8'd255, 32'd200000);
    send_word(8'd255, 32'd206000);
    send_word(8'd0, 32'd206000);
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    proximity <= '0;
    now_ms    <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= REG_THRESHOLD;
    pwdata    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed();

    configure(8'd15, 16'd300, 16'd100);
    random_traffic(120);
    configure(8'd0, 16'hFFFF, 16'hFFFF);
    random_traffic(40);
    configure(8'hFF, 16'd0, 16'd0);
    random_traffic(40);
    configure(8'd128, 16'd1000, 16'd400);
    squeeze_req = 1'b1;
    while (!squeeze_ack) random_press();
    random_traffic(120);
    configure(8'($urandom_range(1, 254)), 16'($urandom_range(0, 2000)),
              16'($urandom_range(0, 500)));
    random_traffic(120);
    configure(8'd40, 16'd300, 16'd100);
    quiet = 1'b1;
    random_traffic(200);

    wait_drained();
    if (errors == 0) begin
      $display("PASS proximity_touch_press_decoder");
    end else begin
      $display("FAIL proximity_touch_press_decoder");
    end
    $finish;
  end

endmodule
